// File: rtl/core/relative_change_event_detector_defines.svh
// assertion macros shared by the relative change event detector rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef RELATIVE_CHANGE_EVENT_DETECTOR_DEFINES_SVH
`define RELATIVE_CHANGE_EVENT_DETECTOR_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked check, skipped while reset is asserted
`define RCED_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rced assertion failed");
// clocked check that also holds during reset
`define RCED_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("rced assertion failed");
`else
`define RCED_ASSERT(lbl, clk, rst_n, prop)
`define RCED_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/core/rced_pkg.sv
// types and constants of the relative change event detector
// used by rced_ctrl, rced_dp and relative_change_event_detector
package rced_pkg;

    localparam int SAMPLE_INPUTS = 4;
    localparam int SAMPLE_W      = 32;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int COUNT_W       = 3;
    localparam int THR_W         = 31;
    localparam int TIME_W        = 32;

    // quotient bits produced by the divider, one per cycle
    localparam int DIV_STEPS = 33;
    localparam int DIV_CNT_W = 6;

    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_SENSORS   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHANGE_THRESHOLD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TIME_STEP        = 2'd2;

    localparam logic [COUNT_W-1:0] ACTIVE_RESET    = 3'd1;
    localparam logic [THR_W-1:0]   THRESHOLD_RESET = 31'd16777216;
    localparam logic [TIME_W-1:0]  TIME_STEP_RESET = 32'd65536;

    localparam logic [31:0] SLOPE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SLOPE_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PREP,
        ST_DIV,
        ST_FIN,
        ST_COMMIT,
        ST_RESULT
    } rced_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic start;
        logic capture;
        logic prep;
        logic div_step;
        logic finish;
        logic next;
        logic commit;
        logic load_out;
    } rced_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic kind;
        logic n_zero;
        logic last;
        logic skip;
        logic div_last;
        logic hit;
        logic out_free;
    } rced_status_t;

endpackage

// File: rtl/core/rced_ctrl.sv
// sequencer of the relative change event detector
// depends on rced_pkg; drives rced_dp through rced_cmd_t
module rced_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  rced_pkg::rced_status_t  status,
    output rced_pkg::rced_cmd_t     cmd
);

    rced_pkg::rced_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rced_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            rced_pkg::ST_IDLE: begin
                // no transfer while reset is held
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.accept = 1'b1;
                    state_next = rced_pkg::ST_LOAD;
                end
            end
            rced_pkg::ST_LOAD: begin
                cmd.start = 1'b1;
                if (!status.kind) begin
                    cmd.capture = 1'b1;
                    state_next  = rced_pkg::ST_RESULT;
                end else if (status.n_zero) begin
                    state_next = rced_pkg::ST_RESULT;
                end else begin
                    state_next = rced_pkg::ST_PREP;
                end
            end
            rced_pkg::ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = status.skip ? rced_pkg::ST_FIN : rced_pkg::ST_DIV;
            end
            rced_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = rced_pkg::ST_FIN;
                end
            end
            rced_pkg::ST_FIN: begin
                cmd.finish = 1'b1;
                if (status.hit || status.last) begin
                    state_next = rced_pkg::ST_COMMIT;
                end else begin
                    cmd.next   = 1'b1;
                    state_next = rced_pkg::ST_PREP;
                end
            end
            rced_pkg::ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = rced_pkg::ST_RESULT;
            end
            rced_pkg::ST_RESULT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = rced_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rced_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/rced_dp.sv
// datapath of the relative change event detector: sensor state, slope
// divider, trigger test, elapsed time and output register; depends on rced_pkg
`include "relative_change_event_detector_defines.svh"

module rced_dp #(
    parameter int SENSORS = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rced_pkg::rced_cmd_t                  cmd,
    output rced_pkg::rced_status_t               status,
    input  logic [rced_pkg::SAMPLE_INPUTS*rced_pkg::SAMPLE_W-1:0] s_tdata,
    input  logic                                 s_tuser,
    input  logic [rced_pkg::COUNT_W-1:0]         n_active,
    input  logic [rced_pkg::THR_W-1:0]           threshold,
    input  logic [rced_pkg::TIME_W-1:0]          time_step,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [rced_pkg::TIME_W-1:0]          m_tdata,
    output logic                                 m_tuser
);

    localparam int LIM   = (SENSORS < rced_pkg::SAMPLE_INPUTS) ? SENSORS
                                                               : rced_pkg::SAMPLE_INPUTS;
    localparam int IDX_W = (LIM > 1) ? $clog2(LIM) : 1;

    logic [31:0]                  samp_reg  [LIM];
    logic [31:0]                  base_reg  [LIM];
    logic [31:0]                  slope_reg [LIM];
    logic                         kind_reg;
    logic [rced_pkg::TIME_W-1:0]  elapsed_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic                         fired_reg;

    logic [31:0]                  rem_reg;
    logic [32:0]                  nq_reg;
    logic [31:0]                  divr_reg;
    logic                         neg_reg;
    logic                         sat_reg;
    logic [rced_pkg::DIV_CNT_W-1:0] cnt_reg;

    logic                         m_valid_reg;
    logic                         m_trig_reg;
    logic [rced_pkg::TIME_W-1:0]  m_time_reg;

    // operand setup
    logic [31:0] sel_samp, sel_base, mag_b;
    logic [32:0] diff, mag_d;
    logic        diff_zero, ovf, neg_now;

    always_comb begin
        sel_samp  = samp_reg[idx_reg];
        sel_base  = base_reg[idx_reg];
        diff      = {sel_samp[31], sel_samp} - {sel_base[31], sel_base};
        mag_d     = diff[32] ? (~diff + 33'd1) : diff;
        mag_b     = sel_base[31] ? (~sel_base + 32'd1) : sel_base;
        neg_now   = diff[32] ^ sel_base[31];
        diff_zero = (diff == 33'd0);
        // quotient would reach 2^33: saturates anyway; also covers a zero baseline
        ovf       = ({8'd0, mag_d} >= {mag_b, 9'd0});
    end

    // divider step
    logic [32:0] trial;
    logic        ge;

    always_comb begin
        trial = {rem_reg, nq_reg[32]};
        ge    = (trial >= {1'b0, divr_reg});
    end

    // slope saturation and trigger test
    logic [31:0] cur, cur_mag, prev;
    logic        hit;

    always_comb begin
        if (neg_reg) begin
            cur = (sat_reg || nq_reg > {1'b0, rced_pkg::SLOPE_MIN}) ? rced_pkg::SLOPE_MIN
                                                                   : (~nq_reg[31:0] + 32'd1);
        end else begin
            cur = (sat_reg || nq_reg > {1'b0, rced_pkg::SLOPE_MAX}) ? rced_pkg::SLOPE_MAX
                                                                   : nq_reg[31:0];
        end
        cur_mag = cur[31] ? (~cur + 32'd1) : cur;
        prev    = slope_reg[idx_reg];
        hit     = (cur_mag > {1'b0, threshold})
               || (!prev[31] && prev != 32'd0 && cur[31])
               || (prev[31] && !cur[31] && cur != 32'd0);
    end

    logic [rced_pkg::TIME_W:0] time_sum;
    assign time_sum = {1'b0, elapsed_reg} + {1'b0, time_step};

    always_comb begin
        status.kind     = kind_reg;
        status.n_zero   = (n_active == '0);
        status.last     = (rced_pkg::COUNT_W'(idx_reg) + 3'd1 == n_active);
        status.skip     = diff_zero || ovf;
        status.div_last = (cnt_reg == '0);
        status.hit      = hit;
        status.out_free = !m_valid_reg || m_tready;
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg <= s_tuser;
            for (int i = 0; i < LIM; i++) begin
                samp_reg[i] <= s_tdata[i*rced_pkg::SAMPLE_W +: rced_pkg::SAMPLE_W];
            end
        end
    end

    // sensor state and sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LIM; i++) begin
                base_reg[i]  <= '0;
                slope_reg[i] <= '0;
            end
            elapsed_reg <= '0;
            idx_reg     <= '0;
            fired_reg   <= 1'b0;
        end else begin
            if (cmd.start) begin
                idx_reg   <= '0;
                fired_reg <= 1'b0;
            end
            if (cmd.capture) begin
                for (int i = 0; i < LIM; i++) begin
                    base_reg[i] <= samp_reg[i];
                end
            end
            if (cmd.finish) begin
                slope_reg[idx_reg] <= cur;
                fired_reg          <= hit;
            end
            if (cmd.next) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.commit) begin
                if (fired_reg) begin
                    for (int i = 0; i < LIM; i++) begin
                        if (rced_pkg::COUNT_W'(i) < n_active) begin
                            base_reg[i] <= samp_reg[i];
                        end
                    end
                    elapsed_reg <= '0;
                end else begin
                    elapsed_reg <= time_sum[rced_pkg::TIME_W] ? '1
                                                              : time_sum[rced_pkg::TIME_W-1:0];
                end
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            rem_reg  <= {8'd0, mag_d[32:9]};
            nq_reg   <= diff_zero ? 33'd0 : {mag_d[8:0], 24'd0};
            divr_reg <= mag_b;
            neg_reg  <= neg_now;
            sat_reg  <= ovf && !diff_zero;
            cnt_reg  <= rced_pkg::DIV_CNT_W'(rced_pkg::DIV_STEPS - 1);
        end else if (cmd.div_step) begin
            rem_reg <= ge ? 32'(trial - {1'b0, divr_reg}) : trial[31:0];
            nq_reg  <= {nq_reg[31:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_trig_reg <= fired_reg;
            m_time_reg <= elapsed_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_time_reg;
    assign m_tuser  = m_trig_reg;

    `RCED_ASSERT(a_no_div_when_sat, aclk, aresetn, cmd.div_step |-> !sat_reg)
    `RCED_ASSERT(a_load_only_free, aclk, aresetn, cmd.load_out |-> (!m_valid_reg || m_tready))
    `RCED_ASSERT(a_fire_clears_time, aclk, aresetn,
                 (cmd.commit && fired_reg) |=> (elapsed_reg == '0))

endmodule

// File: rtl/core/relative_change_event_detector.sv
// relative change event detector (send-on-delta sampling)
//
// input stream: one transfer per item. s_tuser is the kind (0 loads the samples
// as baselines, 1 evaluates a tick); s_tdata carries sample_0..sample_3, signed
// Q16.16. result stream: exactly one transfer per item, m_tuser = trigger,
// m_tdata = elapsed time (Q16.16, saturating). registers are written through
// cfg_we / cfg_addr / cfg_wdata: 0 active sensors, 1 threshold (Q7.24),
// 2 time step; other addresses are ignored.
// one item at a time: accept, load, then per checked sensor (at most 4) a setup
// step, the divider steps and a test step (only setup and test when the slope
// saturates or the difference is zero), then commit and result.
// a capture or a zero active count goes from load straight to result. the
// output register is loaded and s_tready returns in the same cycle, so no new
// item is taken before the last result is in the output register; the
// one-bit-per-cycle slope divider sets the rate while the receiver does not stall.
// the finished result sits in the output register while the next item is taken;
// if the receiver stalls, the following result waits in the result state.
// reset (aresetn low, synchronous) clears baselines, slopes, elapsed time and
// the output valid, holds s_tready low, and restores the register defaults.
module relative_change_event_detector #(
    parameter int SENSORS = 4
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input channel
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // sample_0 [31:0], sample_1 [63:32], sample_2 [95:64], sample_3 [127:96]
    input  logic [rced_pkg::SAMPLE_INPUTS*rced_pkg::SAMPLE_W-1:0] s_tdata,
    // kind [0]
    input  logic                                   s_tuser,
    // result channel
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // elapsed_time [31:0]
    output logic [rced_pkg::TIME_W-1:0]            m_tdata,
    // trigger [0]
    output logic                                   m_tuser,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [rced_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [rced_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    // sensors that have storage and a sample lane
    localparam int LIM = (SENSORS < rced_pkg::SAMPLE_INPUTS) ? SENSORS
                                                             : rced_pkg::SAMPLE_INPUTS;

    logic [rced_pkg::COUNT_W-1:0] active_reg;
    logic [rced_pkg::THR_W-1:0]   threshold_reg;
    logic [rced_pkg::TIME_W-1:0]  time_step_reg;
    logic [rced_pkg::COUNT_W-1:0] n_active;

    rced_pkg::rced_cmd_t    cmd;
    rced_pkg::rced_status_t status;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= rced_pkg::ACTIVE_RESET;
            threshold_reg <= rced_pkg::THRESHOLD_RESET;
            time_step_reg <= rced_pkg::TIME_STEP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                rced_pkg::REG_ACTIVE_SENSORS: begin
                    active_reg <= cfg_wdata[rced_pkg::COUNT_W-1:0];
                end
                rced_pkg::REG_CHANGE_THRESHOLD: begin
                    threshold_reg <= cfg_wdata[rced_pkg::THR_W-1:0];
                end
                rced_pkg::REG_TIME_STEP: begin
                    time_step_reg <= cfg_wdata[rced_pkg::TIME_W-1:0];
                end
                default: begin
                    // unused address, write dropped
                end
            endcase
        end
    end

    // active count clamped to the sensors that exist
    assign n_active = (active_reg > rced_pkg::COUNT_W'(LIM)) ? rced_pkg::COUNT_W'(LIM)
                                                             : active_reg;

    rced_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rced_dp #(
        .SENSORS (SENSORS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .n_active  (n_active),
        .threshold (threshold_reg),
        .time_step (time_step_reg),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: bench/tb_top.sv
// self-checking bench for relative_change_event_detector: stream stimulus, a tick predictor
// and an in-order result checker; depends on rced_pkg and the detector rtl only
`timescale 1ns / 100ps

module tb_top;
    import rced_pkg::*;

    // item kinds carried on s_tuser
    localparam logic KIND_CAPTURE = 1'b0;
    localparam logic KIND_EVAL    = 1'b1;

    // register index past the end of the list, must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_NONE = 2'd3;

    // settle time at the end, longer than the slowest item
    localparam int SETTLE_CYCLES = 160;
    localparam int HOLD_CYCLES   = 600;
    localparam int SWEEP_PHASES  = 8;
    localparam int PHASE_ITEMS   = 225;

    typedef struct packed {
        logic              trigger;
        logic [TIME_W-1:0] elapsed_time;
    } tick_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [SAMPLE_INPUTS*SAMPLE_W-1:0] s_tdata  = '0;
    logic                              s_tuser  = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [TIME_W-1:0]                 m_tdata;
    logic                              m_tuser;
    logic                              cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]             cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]             cfg_wdata = '0;

    // predictor state: mirrors the block's baselines, slopes, elapsed time and registers
    logic signed [SAMPLE_W-1:0] base_val     [SAMPLE_INPUTS];
    logic signed [31:0]         slope_mirror [SAMPLE_INPUTS];
    logic [TIME_W-1:0]          elapsed_acc;
    logic [COUNT_W-1:0]         cfg_active;
    logic [THR_W-1:0]           cfg_threshold;
    logic [TIME_W-1:0]          cfg_step;

    // expected results, oldest first
    tick_result_t pending_results[$];

    int mismatch_count = 0;
    int results_checked = 0;
    int n_captures = 0;
    int n_evals = 0;
    int n_triggers = 0;

    // sender burst control and receiver hold-off request
    int burst_left = 0;
    bit sender_bursty = 1'b1;
    int hold_request = 0;

    always #10 aclk = ~aclk;

    relative_change_event_detector #(
        .SENSORS(4)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // (sample - baseline) * 2^24 / baseline, truncated toward zero, saturated to Q8.24
    function automatic logic signed [31:0] relative_slope(logic signed [31:0] smp,
                                                          logic signed [31:0] base);
        longint          diff;
        longint unsigned mag_diff;
        longint unsigned mag_base;
        longint unsigned quot;
        bit              negative;
        diff = longint'(smp) - longint'(base);
        // zero baseline: 0/0 is a flat slope, anything else pins to the rail
        if (base == 0) begin
            if (diff == 0)
                return '0;
            return (diff > 0) ? SLOPE_MAX : SLOPE_MIN;
        end
        mag_diff = (diff < 0) ? -diff : diff;
        mag_base = (base < 0) ? -longint'(base) : longint'(base);
        negative = (diff < 0) != (base < 0);
        quot = (mag_diff << 24) / mag_base;
        if (negative) begin
            if (quot > 64'h8000_0000)
                quot = 64'h8000_0000;
            quot = -quot;
            return quot[31:0];
        end
        if (quot > 64'h7FFF_FFFF)
            quot = 64'h7FFF_FFFF;
        return quot[31:0];
    endfunction

    // update the mirrored state for one accepted item and queue its result
    task automatic predict_tick(input logic kind, input logic [SAMPLE_INPUTS*SAMPLE_W-1:0] data);
        logic signed [31:0] smp [SAMPLE_INPUTS];
        logic signed [31:0] cur;
        longint             mag;
        longint unsigned    total;
        int                 n;
        bit                 fired;
        tick_result_t       want;
        for (int i = 0; i < SAMPLE_INPUTS; i++)
            smp[i] = data[SAMPLE_W*i +: SAMPLE_W];
        fired = 1'b0;
        if (kind == KIND_CAPTURE) begin
            // capture loads every baseline, slopes and elapsed time stay
            base_val = smp;
            n_captures++;
        end else begin
            n_evals++;
            // counts above the sensor count saturate, zero checks nothing
            n = (cfg_active > SAMPLE_INPUTS) ? SAMPLE_INPUTS : int'(cfg_active);
            if (n > 0) begin
                // stop at the first sensor that fires, later slopes keep their old value
                for (int i = 0; i < n && !fired; i++) begin
                    cur = relative_slope(smp[i], base_val[i]);
                    mag = (cur < 0) ? -longint'(cur) : longint'(cur);
                    if (mag > longint'(cfg_threshold) ||
                        (slope_mirror[i] > 0 && cur < 0) || (slope_mirror[i] < 0 && cur > 0))
                        fired = 1'b1;
                    slope_mirror[i] = cur;
                end
                if (fired) begin
                    for (int i = 0; i < n; i++)
                        base_val[i] = smp[i];
                    elapsed_acc = '0;
                    n_triggers++;
                end else begin
                    // quiet tick: elapsed time grows and sticks at all ones
                    total = elapsed_acc;
                    total += cfg_step;
                    elapsed_acc = (total > 64'hFFFF_FFFF) ? '1 : total[31:0];
                end
            end
        end
        want.trigger      = fired;
        want.elapsed_time = elapsed_acc;
        pending_results.insert(pending_results.size(), want);
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // register write on one rising edge once the block is idle; the mirror follows right away
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        wait_idle(1);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (addr)
            REG_ACTIVE_SENSORS:   cfg_active    = value[COUNT_W-1:0];
            REG_CHANGE_THRESHOLD: cfg_threshold = value[THR_W-1:0];
            REG_TIME_STEP:        cfg_step      = value[TIME_W-1:0];
            default: ;
        endcase
    endtask

    // offer one item, sender idles between bursts of random length
    task automatic send_item(input logic kind, input logic [SAMPLE_INPUTS*SAMPLE_W-1:0] data);
        int gap;
        gap = 0;
        if (sender_bursty && burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= kind;
        // transfer happens on the first rising edge with tready high
        do @(posedge aclk); while (!s_tready);
        predict_tick(kind, data);
    endtask

    // drop valid and wait until every expected result has come back
    task automatic wait_idle(input int settle);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // sample helpers: sample_0 in the low bits
    function automatic logic [SAMPLE_INPUTS*SAMPLE_W-1:0] pack4(logic [31:0] s0, logic [31:0] s1,
                                                                  logic [31:0] s2, logic [31:0] s3);
        return {s3, s2, s1, s0};
    endfunction

    function automatic logic [31:0] wild_value();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            5: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] fresh_baseline();
        if ($urandom_range(0, 9) < 7)
            return int'($urandom) >>> $urandom_range(4, 14);
        return wild_value();
    endfunction

    // a sample a small relative step from the baseline, mostly in the trend direction
    function automatic logic [31:0] near_sample(logic signed [31:0] b, int dir);
        longint mag;
        longint delta;
        longint v;
        if ($urandom_range(0, 6) == 0)
            return b;
        mag = (b < 0) ? -longint'(b) : longint'(b);
        delta = longint'((mag >> $urandom_range(1, 14)) * $urandom_range(0, 4));
        delta = delta + longint'($urandom_range(0, 31));
        v = longint'(b) + dir * delta;
        // occasional turn against the trend
        if ($urandom_range(0, 11) == 0)
            v = longint'(b) - dir * delta;
        if (v > 64'sh7FFF_FFFF)
            v = 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            v = -64'sh8000_0000;
        return v[31:0];
    endfunction

    // occasional captures between runs of ticks near the baselines, with some noise mixed in
    task automatic run_traffic(input int count);
        int                                trend [SAMPLE_INPUTS];
        logic [SAMPLE_INPUTS*SAMPLE_W-1:0] data;
        int                                pick;
        for (int i = 0; i < SAMPLE_INPUTS; i++)
            trend[i] = $urandom_range(0, 1) ? 1 : -1;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                for (int i = 0; i < SAMPLE_INPUTS; i++) begin
                    data[SAMPLE_W*i +: SAMPLE_W] = fresh_baseline();
                    trend[i] = $urandom_range(0, 1) ? 1 : -1;
                end
                send_item(KIND_CAPTURE, data);
            end else if (pick < 18) begin
                for (int i = 0; i < SAMPLE_INPUTS; i++)
                    data[SAMPLE_W*i +: SAMPLE_W] = wild_value();
                send_item(logic'($urandom_range(0, 1)), data);
            end else begin
                for (int i = 0; i < SAMPLE_INPUTS; i++)
                    data[SAMPLE_W*i +: SAMPLE_W] = near_sample(base_val[i], trend[i]);
                if ($urandom_range(0, 19) == 0)
                    trend[$urandom_range(0, SAMPLE_INPUTS-1)] *= -1;
                send_item(KIND_EVAL, data);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // corner cases one item at a time, starting from the reset registers
    task automatic test_directed();
        // default config, zero baselines: 0/0 is flat, then a jump off zero pins high
        send_item(KIND_EVAL, pack4(32'h0, 32'h0, 32'h0, 32'h0));
        send_item(KIND_EVAL, pack4(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0));
        // largest positive swing against the most negative baseline
        send_item(KIND_CAPTURE, pack4(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_item(KIND_EVAL, pack4(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0));

        // threshold near its maximum: only sign flips and a slope pinned low can fire
        write_reg(REG_ACTIVE_SENSORS, 32'd4);
        write_reg(REG_CHANGE_THRESHOLD, 32'h7FFF_FFFF);
        write_reg(REG_TIME_STEP, 32'h0001_0000);
        // baselines 1.0, -1.0, 2.0, 0
        send_item(KIND_CAPTURE, pack4(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0));
        // +0.5 on the first two, flat on the others
        send_item(KIND_EVAL, pack4(32'h0001_8000, 32'hFFFE_8000, 32'h0002_0000, 32'h0));
        // sensor 0 turns to -0.5: flip, later slopes left alone
        send_item(KIND_EVAL, pack4(32'h0000_8000, 32'hFFFE_8000, 32'h0002_0000, 32'h0));
        // back to a flat slope is no flip
        send_item(KIND_EVAL, pack4(32'h0000_8000, 32'hFFFE_8000, 32'h0002_0000, 32'h0));
        // zero baseline with a negative step pins low, magnitude above the max threshold
        send_item(KIND_EVAL, pack4(32'h0000_8000, 32'hFFFE_8000, 32'h0002_0000, 32'hFFFF_FFFF));
        send_item(KIND_CAPTURE, pack4(32'h0, 32'h0, 32'h0, 32'h0));
        send_item(KIND_EVAL, pack4(32'h0, 32'h0, 32'h0, 32'h0));

        // zero threshold: any nonzero slope fires
        write_reg(REG_CHANGE_THRESHOLD, 32'h0);
        send_item(KIND_CAPTURE, pack4(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_item(KIND_EVAL, pack4(32'h0001_0000, 32'h0001_0000, 32'h0001_0001, 32'h0001_0000));

        // elapsed time saturates with the largest step, holds with a zero step
        write_reg(REG_CHANGE_THRESHOLD, 32'hFFFF_FFFF);
        write_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
        send_item(KIND_EVAL, pack4(32'h0001_0000, 32'h0001_0000, 32'h0001_0001, 32'h0001_0000));
        send_item(KIND_EVAL, pack4(32'h0001_0000, 32'h0001_0000, 32'h0001_0001, 32'h0001_0000));
        write_reg(REG_TIME_STEP, 32'h0);
        send_item(KIND_EVAL, pack4(32'h0001_0000, 32'h0001_0000, 32'h0001_0001, 32'h0001_0000));

        // no active sensors: nothing checked, nothing changes
        write_reg(REG_ACTIVE_SENSORS, 32'd0);
        write_reg(REG_CHANGE_THRESHOLD, 32'h0);
        send_item(KIND_EVAL, pack4(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF));
        // oversized count saturates to all sensors
        write_reg(REG_ACTIVE_SENSORS, 32'd7);
        write_reg(REG_TIME_STEP, 32'h0001_0000);
        send_item(KIND_EVAL, pack4(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0002));
        // write past the register list is dropped
        write_reg(REG_NONE, 32'h0);
        send_item(KIND_EVAL, pack4(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0002));
        send_item(KIND_CAPTURE, pack4(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(KIND_EVAL, pack4(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        wait_idle(8);
    endtask

    // random traffic under a series of register settings, extremes included
    task automatic test_config_sweep();
        logic [CFG_DATA_W-1:0] act;
        logic [CFG_DATA_W-1:0] thr;
        logic [CFG_DATA_W-1:0] stp;
        for (int p = 0; p < SWEEP_PHASES; p++) begin
            case (p)
                0: begin act = 4; thr = 32'h0040_0000; stp = 32'h0001_0000; end
                1: begin act = 1; thr = 32'h0100_0000; stp = $urandom; end
                2: begin act = 4; thr = 32'h7FFF_FFFF; stp = 32'hFFFF_FFFF; end
                3: begin act = 4; thr = 32'h0; stp = 32'h0; end
                4: begin act = 2; thr = 32'h0010_0000; stp = $urandom >> 8; end
                5: begin act = 3; thr = $urandom >> 1; stp = $urandom; end
                6: begin act = $urandom_range(0, 7); thr = $urandom; stp = $urandom; end
                default: begin act = 4; thr = 32'h0400_0000; stp = 32'h0001_0000; end
            endcase
            write_reg(REG_ACTIVE_SENSORS, act);
            write_reg(REG_CHANGE_THRESHOLD, thr);
            write_reg(REG_TIME_STEP, stp);
            run_traffic(PHASE_ITEMS);
            wait_idle(8);
        end
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        write_reg(REG_ACTIVE_SENSORS, 32'd1);
        write_reg(REG_CHANGE_THRESHOLD, 32'h0040_0000);
        sender_bursty = 1'b0;
        hold_request  = HOLD_CYCLES;
        run_traffic(40);
        sender_bursty = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // receiver: alternating ready and stall segments, plus long hold-offs on request
    // ------------------------------------------------------------------
    initial begin : receiver
        int seg;
        bit ready_now;
        ready_now = 1'b0;
        forever begin
            if (hold_request > 0) begin
                seg = hold_request;
                hold_request = 0;
                repeat (seg) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
            end else begin
                ready_now = !ready_now;
                if (ready_now)
                    seg = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 40);
                else
                    seg = $urandom_range(1, 16);
                repeat (seg) begin
                    @(negedge aclk);
                    m_tready <= ready_now;
                    if (hold_request > 0)
                        break;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker: each transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        tick_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: trigger %0d elapsed_time %h",
                       m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_tuser !== want.trigger) begin
                    $error("trigger mismatch: expected %0d, actual %0d", want.trigger, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata !== want.elapsed_time) begin
                    $error("elapsed_time mismatch: expected %h, actual %h",
                           want.elapsed_time, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        // mirror starts from the reset state
        for (int i = 0; i < SAMPLE_INPUTS; i++) begin
            base_val[i]     = '0;
            slope_mirror[i] = '0;
        end
        elapsed_acc   = '0;
        cfg_active    = ACTIVE_RESET;
        cfg_threshold = THRESHOLD_RESET;
        cfg_step      = TIME_STEP_RESET;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_config_sweep();
        test_backpressure();
        wait_idle(SETTLE_CYCLES);

        $display("covered %0d items: %0d baseline captures, %0d evaluations, %0d triggered ticks",
                 n_captures + n_evals, n_captures, n_evals, n_triggers);
        $display("checked %0d result transfers, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #30_000_000;
        $error("timeout: detector stopped making progress");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rced_pkg.sv
rtl/core/rced_ctrl.sv
rtl/core/rced_dp.sv
rtl/core/relative_change_event_detector.sv
bench/tb_top.sv
